FILE: rtl/ascii_command_frame_parser_assert.svh
// Assertion macros for the ASCII command frame parser
`ifndef ASCII_COMMAND_FRAME_PARSER_ASSERT_SVH
`define ASCII_COMMAND_FRAME_PARSER_ASSERT_SVH

// cond must hold at every clock edge out of reset
`define ACFP_CHECK(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// cons must hold in the same cycle whenever ante holds
`define ACFP_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

FILE: rtl/acfp_pkg.sv
// Types, codes and constants shared by the command frame parser modules
`timescale 1ns / 1ps

package acfp_pkg;

  localparam int FRAME_BYTES_DEF = 50;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_X     = 8'h58;
  localparam logic [7:0] CHAR_COMMA = 8'h2c;
  localparam logic [7:0] CHAR_PLUS  = 8'h2b;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [7:0] CHAR_A     = 8'h41;
  localparam logic [7:0] CHAR_T     = 8'h54;
  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_AT    = 8'h40;

  typedef enum logic [3:0] {
    PH_MODE  = 4'd0,
    PH_COMMA = 4'd1,
    PH_LEAD1 = 4'd2,
    PH_BODY1 = 4'd3,
    PH_LEAD2 = 4'd4,
    PH_BODY2 = 4'd5,
    PH_LEAD3 = 4'd6,
    PH_BODY3 = 4'd7,
    PH_DONE  = 4'd8,
    PH_FAIL  = 4'd9
  } phase_t;

  typedef enum logic [1:0] {
    REPLY_ACK  = 2'd0,
    REPLY_NACK = 2'd1,
    REPLY_AT   = 2'd2
  } reply_t;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_SPEED   = 2'd1,
    ACT_STEPPER = 2'd2
  } action_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       obstructed;
  } byte_item_t;

  typedef struct packed {
    logic [1:0]        reply_kind;
    logic [1:0]        action;
    logic signed [7:0] first_value;
    logic signed [7:0] second_value;
    logic              fire;
    logic              obstruct_echo;
  } result_item_t;

endpackage

FILE: rtl/ascii_command_frame_parser.sv
// A frame-ending byte's result is registered when the byte is transferred.
// Throughput: one byte per cycle; the per-byte match update is a single pass
// between the frame state registers and the result register.
// A byte is taken while a result waits, unless that result is stalled.
// Reset (rst, synchronous) empties the frame and drops any pending result.
`timescale 1ns / 1ps
`include "ascii_command_frame_parser_assert.svh"

module ascii_command_frame_parser #(
  parameter int FRAME_BYTES = acfp_pkg::FRAME_BYTES_DEF  // 8 .. 256
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   byte_valid,
  output logic                   byte_ready,
  input  acfp_pkg::byte_item_t   byte_item,
  output logic                   result_valid,
  input  logic                   result_ready,
  output acfp_pkg::result_item_t result_item
);
  import acfp_pkg::*;

  logic         step, frame_end;
  result_item_t result_next;

  assign byte_ready = !result_valid || result_ready;
  assign step       = byte_valid && byte_ready;

  acfp_parser #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_parser (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .item     (byte_item),
    .frame_end(frame_end),
    .result   (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (step && frame_end) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && frame_end) begin
      result_item <= result_next;
    end
  end

  `ACFP_IMPLIES(a_action_needs_ack, result_valid && result_item.action != ACT_NONE,
                result_item.reply_kind == REPLY_ACK && !result_item.obstruct_echo,
                "action on a frame that was not an unobstructed ACK")
  `ACFP_IMPLIES(a_fire_needs_stepper, result_valid && result_item.fire,
                result_item.action == ACT_STEPPER, "fire without stepper action")
  `ACFP_IMPLIES(a_at_frame_quiet, result_valid && result_item.reply_kind == REPLY_AT,
                result_item.action == ACT_NONE && !result_item.obstruct_echo,
                "AT+ frame carries an action or an echo")
  `ACFP_CHECK(a_idle_values_zero,
              !result_valid || result_item.action != ACT_NONE ||
              (result_item.first_value == 8'sd0 && result_item.second_value == 8'sd0),
              "values nonzero without an action")

endmodule

FILE: rtl/acfp_parser.sv
// Per-byte frame matcher: holds the frame state and forms the result at frame end
`timescale 1ns / 1ps

module acfp_parser #(
  parameter int FRAME_BYTES = acfp_pkg::FRAME_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  acfp_pkg::byte_item_t  item,
  output logic                  frame_end,
  output acfp_pkg::result_item_t result
);
  import acfp_pkg::*;

  localparam int CW = $clog2(FRAME_BYTES);
  localparam logic [CW-1:0] LAST_COUNT = CW'(FRAME_BYTES - 1);

  logic [CW-1:0] stored_count, stored_count_next;
  phase_t        parse_phase, parse_phase_next;
  logic [7:0]    mode_char, mode_char_next;
  logic          negative_sign, negative_sign_next;
  logic          digit_seen, digit_seen_next;
  logic [7:0]    first_accum, first_accum_next;
  logic [7:0]    second_accum, second_accum_next;
  logic          third_nonzero, third_nonzero_next;
  logic          string_cut, string_cut_next;
  logic [1:0]    prefix_match, prefix_match_next;

  logic [7:0] c;
  logic [3:0] d;
  logic       is_x, is_ws, is_dig, match_en, prefix_hit;
  logic       do_digit, dig_neg, ok;
  phase_t     dig_phase;
  logic [7:0] prefix_char;

  function automatic logic [7:0] acc_digit(input logic [7:0] acc, input logic [3:0] dv,
                                           input logic neg);
    logic [7:0] m;
    m = (acc << 3) + (acc << 1);
    return neg ? m - {4'b0000, dv} : m + {4'b0000, dv};
  endfunction

  assign c      = item.rx_byte;
  assign d      = 4'(c - CHAR_ZERO);
  assign is_x   = (c == CHAR_X);
  assign is_ws  = (c == CHAR_SPACE) || (c inside {[CHAR_TAB:CHAR_CR]});
  assign is_dig = c inside {[CHAR_ZERO:CHAR_NINE]};
  // count never sits at the last slot between bytes, so every non-X byte up to the first NUL is stored
  assign match_en = !is_x && !string_cut;

  always_comb begin
    case (prefix_match)
      2'd0:    prefix_char = CHAR_A;
      2'd1:    prefix_char = CHAR_T;
      default: prefix_char = CHAR_PLUS;
    endcase
  end

  assign prefix_hit = (prefix_match != 2'd3) &&
                      (stored_count == CW'(prefix_match)) && (c == prefix_char);

  always_comb begin
    parse_phase_next   = parse_phase;
    mode_char_next     = mode_char;
    negative_sign_next = negative_sign;
    digit_seen_next    = digit_seen;
    first_accum_next   = first_accum;
    second_accum_next  = second_accum;
    third_nonzero_next = third_nonzero;
    string_cut_next    = string_cut;
    prefix_match_next  = prefix_match;
    do_digit           = 1'b0;
    dig_neg            = 1'b0;
    dig_phase          = parse_phase;
    stored_count_next  = is_x ? stored_count : stored_count + CW'(1);

    if (match_en) begin
      if (prefix_hit) begin
        prefix_match_next = prefix_match + 2'd1;
      end
      if (c == CHAR_NUL) begin
        string_cut_next = 1'b1;
      end
      case (parse_phase)
        PH_MODE: begin
          if (c == CHAR_NUL) begin
            parse_phase_next = PH_FAIL;
          end else begin
            mode_char_next   = c;
            parse_phase_next = PH_COMMA;
          end
        end
        PH_COMMA: begin
          parse_phase_next = (c == CHAR_COMMA) ? PH_LEAD1 : PH_FAIL;
        end
        PH_LEAD1, PH_LEAD2, PH_LEAD3: begin
          if (!is_ws) begin
            negative_sign_next = 1'b0;
            digit_seen_next    = 1'b0;
            if (c == CHAR_PLUS || c == CHAR_MINUS) begin
              negative_sign_next = (c == CHAR_MINUS);
              parse_phase_next   = phase_t'(parse_phase + 4'd1);
            end else if (is_dig) begin
              parse_phase_next = phase_t'(parse_phase + 4'd1);
              digit_seen_next  = 1'b1;
              do_digit         = 1'b1;
              dig_phase        = phase_t'(parse_phase + 4'd1);
            end else begin
              parse_phase_next = PH_FAIL;
            end
          end
        end
        PH_BODY1, PH_BODY2, PH_BODY3: begin
          if (is_dig) begin
            digit_seen_next = 1'b1;
            do_digit        = 1'b1;
            dig_neg         = negative_sign;
          end else if (!digit_seen) begin
            parse_phase_next = PH_FAIL;
          end else if (parse_phase == PH_BODY3) begin
            parse_phase_next = PH_DONE;
          end else begin
            parse_phase_next = (c == CHAR_COMMA) ? phase_t'(parse_phase + 4'd1) : PH_FAIL;
          end
        end
        default: begin
        end
      endcase

      if (do_digit) begin
        case (dig_phase)
          PH_BODY1: first_accum_next  = acc_digit(first_accum, d, dig_neg);
          PH_BODY2: second_accum_next = acc_digit(second_accum, d, dig_neg);
          default:  third_nonzero_next = third_nonzero || (d != 4'd0);
        endcase
      end
    end
  end

  assign frame_end = is_x || (stored_count_next == LAST_COUNT);

  // text ends at frame end as if a NUL followed
  assign ok = (parse_phase_next == PH_DONE) || (parse_phase_next == PH_BODY3 && digit_seen_next);

  always_comb begin
    result               = '0;
    result.obstruct_echo = item.obstructed;
    if (ok) begin
      result.reply_kind = REPLY_ACK;
      if (!item.obstructed && mode_char_next == CHAR_DOLLAR) begin
        result.action       = ACT_SPEED;
        result.first_value  = first_accum_next;
        result.second_value = second_accum_next;
      end else if (!item.obstructed && mode_char_next == CHAR_AT) begin
        result.action       = ACT_STEPPER;
        result.first_value  = first_accum_next;
        result.second_value = second_accum_next;
        result.fire         = third_nonzero_next;
      end
    end else if (prefix_match_next == 2'd3) begin
      result.reply_kind    = REPLY_AT;
      result.obstruct_echo = 1'b0;
    end else begin
      result.reply_kind = REPLY_NACK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && frame_end)) begin
      stored_count  <= '0;
      parse_phase   <= PH_MODE;
      mode_char     <= '0;
      negative_sign <= 1'b0;
      digit_seen    <= 1'b0;
      first_accum   <= '0;
      second_accum  <= '0;
      third_nonzero <= 1'b0;
      string_cut    <= 1'b0;
      prefix_match  <= '0;
    end else if (step) begin
      stored_count  <= stored_count_next;
      parse_phase   <= parse_phase_next;
      mode_char     <= mode_char_next;
      negative_sign <= negative_sign_next;
      digit_seen    <= digit_seen_next;
      first_accum   <= first_accum_next;
      second_accum  <= second_accum_next;
      third_nonzero <= third_nonzero_next;
      string_cut    <= string_cut_next;
      prefix_match  <= prefix_match_next;
    end
  end

endmodule
